[rtl/core/assert_macros.svh]
// Assertion macros used by the byte trace formatter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif
`endif

[rtl/core/btf_pkg.sv]
// Shared types, character codes and helper functions of the byte trace formatter.
package btf_pkg;

	localparam int unsigned MaxChars = 12;
	localparam int unsigned BodyChars = 9;
	localparam int unsigned CharW = 7;
	localparam int unsigned CntW = 4;
	localparam int unsigned LineCntW = 5;

	localparam logic [1:0] CfgNumberBase = 2'd0;
	localparam logic [1:0] CfgLineWrap = 2'd1;

	localparam logic [CharW-1:0] ChLf = 7'h0A;
	localparam logic [CharW-1:0] ChCr = 7'h0D;
	localparam logic [CharW-1:0] ChGt = 7'h3E;
	localparam logic [CharW-1:0] ChLt = 7'h3C;
	localparam logic [CharW-1:0] ChSp = 7'h20;
	localparam logic [CharW-1:0] ChZero = 7'h30;
	localparam logic [CharW-1:0] ChOne = 7'h31;
	localparam logic [CharW-1:0] ChUpperA = 7'h41;

	typedef enum logic [1:0] {
		BASE_BIN = 2'd0,
		BASE_OCT = 2'd1,
		BASE_DEC = 2'd2,
		BASE_HEX = 2'd3
	} base_t;

	typedef enum logic [1:0] {
		DIR_TX = 2'd0,
		DIR_RX = 2'd1,
		DIR_NONE = 2'd2
	} shown_dir_t;

	typedef struct packed {
		logic [MaxChars-1:0][CharW-1:0] chars;
		logic [CntW-1:0] count;
	} fmt_line_t;

	function automatic logic [CharW-1:0] digit_char(input logic [3:0] d);
		logic [CharW-1:0] r;
		if (d < 4'd10) begin
			r = ChZero + {3'b000, d};
		end else begin
			r = ChUpperA + {3'b000, d} - 7'd10;
		end
		return r;
	endfunction

	function automatic logic [LineCntW-1:0] wrap_limit(input base_t b);
		logic [LineCntW-1:0] r;
		unique case (b)
			BASE_BIN: r = 5'd2;
			BASE_OCT: r = 5'd8;
			BASE_DEC: r = 5'd10;
			BASE_HEX: r = 5'd16;
			default: r = 5'd16;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/btf_format.sv]
// Formatter: turns one traced byte into its line of characters and tracks header state.
module btf_format (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             data_byte,
	input  logic                   direction,
	input  btf_pkg::base_t         number_base,
	input  logic                   line_wrap_enable,
	input  logic                   load,
	output btf_pkg::fmt_line_t     line
);

	btf_pkg::shown_dir_t shown_dir_q, shown_dir_next;
	logic [btf_pkg::LineCntW-1:0] bytes_q, bytes_next, bytes_inc;
	logic [btf_pkg::CharW-1:0] body [btf_pkg::BodyChars];
	logic [btf_pkg::CntW-1:0] body_len;
	btf_pkg::shown_dir_t dir_code;
	logic hdr;
	logic [1:0] hund;
	logic [7:0] rem_dec;
	logic [15:0] tens_prod;
	logic [3:0] tens, ones;
	logic [7:0] tens_x10;

	assign dir_code = direction ? btf_pkg::DIR_RX : btf_pkg::DIR_TX;
	assign hdr = (shown_dir_q != dir_code);

	// Decimal digits: hundreds by compare, tens by reciprocal multiply (x*205>>11).
	always_comb begin
		if (data_byte >= 8'd200) begin
			hund = 2'd2;
			rem_dec = data_byte - 8'd200;
		end else if (data_byte >= 8'd100) begin
			hund = 2'd1;
			rem_dec = data_byte - 8'd100;
		end else begin
			hund = 2'd0;
			rem_dec = data_byte;
		end
		tens_prod = {8'd0, rem_dec} * 16'd205;
		tens = tens_prod[14:11];
		tens_x10 = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0};
		ones = 4'(rem_dec - tens_x10);
	end

	always_comb begin
		for (int i = 0; i < btf_pkg::BodyChars; i++) begin
			body[i] = btf_pkg::ChSp;
		end
		unique case (number_base)
			btf_pkg::BASE_BIN: begin
				for (int i = 0; i < 8; i++) begin
					body[i+1] = data_byte[7-i] ? btf_pkg::ChOne : btf_pkg::ChZero;
				end
				body_len = 4'd9;
			end
			btf_pkg::BASE_OCT: begin
				body[1] = btf_pkg::digit_char({2'b00, data_byte[7:6]});
				body[2] = btf_pkg::digit_char({1'b0, data_byte[5:3]});
				body[3] = btf_pkg::digit_char({1'b0, data_byte[2:0]});
				body_len = 4'd4;
			end
			btf_pkg::BASE_DEC: begin
				// blank leading zeros, always print the ones digit
				body[1] = (hund == 2'd0) ? btf_pkg::ChSp : btf_pkg::digit_char({2'b00, hund});
				body[2] = (hund == 2'd0 && tens == 4'd0) ? btf_pkg::ChSp
					: btf_pkg::digit_char(tens);
				body[3] = btf_pkg::digit_char(ones);
				body_len = 4'd4;
			end
			btf_pkg::BASE_HEX: begin
				body[1] = btf_pkg::digit_char(data_byte[7:4]);
				body[2] = btf_pkg::digit_char(data_byte[3:0]);
				body_len = 4'd3;
			end
			default: begin
				body_len = 4'd3;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < btf_pkg::MaxChars; i++) begin
			line.chars[i] = btf_pkg::ChSp;
		end
		if (hdr) begin
			line.chars[0] = btf_pkg::ChLf;
			line.chars[1] = btf_pkg::ChCr;
			line.chars[2] = direction ? btf_pkg::ChLt : btf_pkg::ChGt;
			for (int j = 0; j < btf_pkg::BodyChars; j++) begin
				line.chars[j+3] = body[j];
			end
			line.count = body_len + 4'd3;
		end else begin
			for (int j = 0; j < btf_pkg::BodyChars; j++) begin
				line.chars[j] = body[j];
			end
			line.count = body_len;
		end
	end

	// Header and per-line byte count after this byte.
	always_comb begin
		shown_dir_next = hdr ? dir_code : shown_dir_q;
		bytes_inc = bytes_q + 5'd1;
		bytes_next = bytes_q;
		if (line_wrap_enable) begin
			if (bytes_inc >= btf_pkg::wrap_limit(number_base)) begin
				shown_dir_next = btf_pkg::DIR_NONE;
				bytes_next = '0;
			end else begin
				bytes_next = bytes_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_dir_q <= btf_pkg::DIR_NONE;
			bytes_q <= '0;
		end else if (load) begin
			shown_dir_q <= shown_dir_next;
			bytes_q <= bytes_next;
		end
	end

endmodule

[rtl/core/btf_serializer.sv]
// Serializer: holds one formatted line and sends it out one character per cycle while out_ready allows.
`include "assert_macros.svh"
module btf_serializer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  btf_pkg::fmt_line_t     line,
	output logic                   buf_free,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [btf_pkg::CharW-1:0] char_code,
	output logic                   last
);

	logic [btf_pkg::MaxChars-1:0][btf_pkg::CharW-1:0] chars_q;
	logic [btf_pkg::CntW-1:0] rem_q;
	logic out_valid_q, last_q;
	logic [btf_pkg::CharW-1:0] char_q;
	logic pop;

	assign pop = (rem_q != '0) && (!out_valid_q || out_ready);
	assign buf_free = (rem_q == '0) || (pop && rem_q == 4'd1);

	always_ff @(posedge clk) begin
		if (load) begin
			chars_q <= line.chars;
		end else if (pop) begin
			chars_q <= {btf_pkg::ChSp, chars_q[btf_pkg::MaxChars-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				rem_q <= line.count;
			end else if (pop) begin
				rem_q <= rem_q - 4'd1;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			char_q <= chars_q[0];
			last_q <= (rem_q == 4'd1);
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last = last_q;

	`ASSERT_NEVER(a_rem_range, clk, arst_n, rem_q > btf_pkg::CntW'(btf_pkg::MaxChars), "remaining count over line length")
	`ASSERT_ALWAYS(a_pop_fills_out, clk, arst_n, pop |=> out_valid_q, "popped character not in output register")
	`ASSERT_ALWAYS(a_last_frees, clk, arst_n, (pop && rem_q == 4'd1 && !load) |=> (rem_q == '0 && last_q), "final character did not free the line buffer")
	`ASSERT_ALWAYS(a_load_when_free, clk, arst_n, load |-> buf_free, "line loaded over undelivered characters")

endmodule

[rtl/core/byte_trace_text_formatter.sv]
// Top level of the byte trace formatter: config registers, input stage, formatter, serializer.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+---------------------------------
//  in      | in_valid, in_ready, data_byte, direction  | one traced byte per transaction
//  out     | out_valid, out_ready, char_code, last     | one ASCII character per transaction
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write, always ready
//
// Each byte yields 3 to 12 characters: a space plus 8/3/3/2 digits (binary, octal,
// decimal, hex), plus 3 when a newline/CR/marker header comes first. The line buffer
// drains one character per cycle while out is not stalled; the next byte is taken in the
// cycle its predecessor's final character leaves. The first character passes through the
// input stage, the line buffer and the output register. Reset clears all control state
// at once; no clearing pass. A stall on out holds the output register and then the line
// buffer, and in_ready drops once the input stage fills.
module byte_trace_text_formatter (
	input  logic                   clk,
	input  logic                   arst_n,
	// input channel
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             data_byte,
	input  logic                   direction,
	// output channel
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [btf_pkg::CharW-1:0] char_code,
	output logic                   last,
	// configuration channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [1:0]             cfg_data
);

	btf_pkg::base_t number_base_q;
	logic line_wrap_enable_q;
	logic valid_s1;
	logic [7:0] data_byte_s1;
	logic direction_s1;
	logic buf_free;
	logic load;
	btf_pkg::fmt_line_t line;

	// Register writes land at once; the port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= btf_pkg::BASE_HEX;
			line_wrap_enable_q <= 1'b1;
		end else if (cfg_valid) begin
			priority if (cfg_index == btf_pkg::CfgNumberBase) begin
				number_base_q <= btf_pkg::base_t'(cfg_data);
			end else if (cfg_index == btf_pkg::CfgLineWrap) begin
				line_wrap_enable_q <= cfg_data[0];
			end else begin
				// drop writes to unknown indexes
				line_wrap_enable_q <= line_wrap_enable_q;
			end
		end
	end

	// Input stage: advance into the line buffer as soon as it frees up.
	assign load = valid_s1 && buf_free;
	assign in_ready = !valid_s1 || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_byte_s1 <= data_byte;
			direction_s1 <= direction;
		end
	end

	// Format the held byte; header state updates when the line is loaded.
	btf_format u_format (
		.clk              (clk),
		.arst_n           (arst_n),
		.data_byte        (data_byte_s1),
		.direction        (direction_s1),
		.number_base      (number_base_q),
		.line_wrap_enable (line_wrap_enable_q),
		.load             (load),
		.line             (line)
	);

	// Drain the line one character per cycle, while out is not stalled, through the output register.
	btf_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.line      (line),
		.buf_free  (buf_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_code (char_code),
		.last      (last)
	);

endmodule
